>>> src/hupw_pkg.sv
// ----------------------------------------------------------------------------
// hupw_pkg
// shared types, constants and the header key table for the upload page writer
// ----------------------------------------------------------------------------
`default_nettype none

package hupw_pkg;

  // default geometry
  localparam int PAGE_BYTES_DEF   = 256;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int ADDRESS_BITS_DEF = 24;

  // field widths fixed by the interface
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 24;
  localparam int COUNT_W = 24;
  localparam int FLASH_W = 24;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // register map, index is paddr[2]
  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_MAX_LENGTH   = 1'b1;

  localparam logic [CFG_W-1:0] BASE_ADDRESS_RST = 24'h001000;
  localparam logic [CFG_W-1:0] MAX_LENGTH_RST   = 24'd491520;

  // result kinds
  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // content length accumulator
  localparam int              LEN_W     = 25;
  localparam logic [LEN_W-1:0] LEN_MAX  = 25'h1FF_FFFF;
  localparam logic [LEN_W-1:0] LEN_SAT  = LEN_MAX / 10;
  localparam int              KEY_LEN   = 15;
  localparam int              PIDX_W    = 4;

  typedef enum logic [1:0] {
    NP_SEARCH = 2'd0,
    NP_SKIP   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_OVER   = 2'd3
  } np_t;

  typedef struct packed {
    np_t               np;
    logic [PIDX_W-1:0] pidx;
    logic [LEN_W-1:0]  len;
    logic [1:0]        crlf;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{np: NP_SEARCH, pidx: '0, len: '0, crlf: '0};

  // upper-case "CONTENT-LENGTH:"
  function automatic logic [BYTE_W-1:0] key_char(input logic [PIDX_W-1:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "O";
      4'd2:    c = "N";
      4'd3:    c = "T";
      4'd4:    c = "E";
      4'd5:    c = "N";
      4'd6:    c = "T";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "E";
      4'd10:   c = "N";
      4'd11:   c = "G";
      4'd12:   c = "T";
      4'd13:   c = "H";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/http_upload_page_writer_unit.sv
// ----------------------------------------------------------------------------
// http_upload_page_writer_unit
// http upload parser that turns the request body into flash write transfers
// ----------------------------------------------------------------------------
// usage
//   input channel: one request byte per transfer, start_of_request marks the
//   first byte of a new request and clears the parser before that byte
//   result channel: one transfer per body byte (data, flash address, erase
//   flag, page end, last, running count) or one reject transfer when the
//   content length at the end of the header is zero or above max_length
//   header bytes and bytes after the body produce no transfer
//   config port: apb writes to base_address (0x0) and max_length (0x4),
//   base_address is sampled at the end of the header
// timing
//   one byte per cycle sustained while out_stall is low; each byte goes
//   through the input register, single-pass parse logic and result register
//   the rate is set by the per-byte state update: key match, multiply-by-ten
//   accumulate and address increment all sit in the single-pass parse logic
// reset and stall
//   reset puts the parser in the header phase with both registers at their
//   defaults, so a stream without a start mark is parsed as one request
//   when out_stall holds a pending result, the input register fills and
//   in_stall rises in the same cycle; nothing is dropped
// ----------------------------------------------------------------------------
`default_nettype none

module http_upload_page_writer_unit #(
  parameter int PAGE_BYTES   = hupw_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = hupw_pkg::SECTOR_BYTES_DEF,
  parameter int ADDRESS_BITS = hupw_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hupw_pkg::BYTE_W-1:0]       in_byte_value,
  input  wire logic                              in_start_of_request,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_result_kind,
  output logic [hupw_pkg::BYTE_W-1:0]            out_body_byte,
  output logic [hupw_pkg::FLASH_W-1:0]           out_flash_address,
  output logic                                   out_erase_sector,
  output logic                                   out_page_end,
  output logic                                   out_last,
  output logic [hupw_pkg::COUNT_W-1:0]           out_bytes_received,
  // config port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hupw_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [hupw_pkg::DATA_W-1:0]       pwdata,
  output logic [hupw_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);

  localparam int PG_LOG = $clog2(PAGE_BYTES);
  localparam int SB_LOG = $clog2(SECTOR_BYTES);
  // sector number width, at least one bit when a sector spans the address space
  localparam int SEC_W  = (ADDRESS_BITS > SB_LOG) ? ADDRESS_BITS - SB_LOG : 1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [hupw_pkg::CFG_W-1:0] base_r;
  logic [hupw_pkg::CFG_W-1:0] max_len_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= hupw_pkg::BASE_ADDRESS_RST;
      max_len_r <= hupw_pkg::MAX_LENGTH_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == hupw_pkg::REG_BASE_ADDRESS) begin
        base_r <= pwdata[hupw_pkg::CFG_W-1:0];
      end else begin
        max_len_r <= pwdata[hupw_pkg::CFG_W-1:0];
      end
    end
  end

  // read mux, registers are zero-extended to the bus
  assign prdata = (paddr[2] == hupw_pkg::REG_MAX_LENGTH) ?
                  hupw_pkg::DATA_W'(max_len_r) : hupw_pkg::DATA_W'(base_r);

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                        s1_valid_r;
  logic [hupw_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_sor_r;
  logic                        s1_go;
  logic                        out_valid_r;

  // the held byte moves on whenever the result register can take a new value
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_value;
      s1_sor_r  <= in_start_of_request;
    end
  end

  // --------------------------------------------------------------------------
  // parser state
  // --------------------------------------------------------------------------
  phase_t                       phase_r, phase_cur, phase_nxt;
  hupw_pkg::scan_state_t        scan_r, scan_cur, scan_nxt, scan_out;
  logic                         hdr_end;
  logic [hupw_pkg::COUNT_W-1:0] rc_r, rc_nxt, rc_inc;
  logic [ADDRESS_BITS-1:0]      wr_addr_r, wr_addr_nxt, addr_full;
  logic [SEC_W-1:0]             sec_r, sec_nxt, sec_cur;
  logic                         sec_valid_r, sec_valid_nxt;
  logic [31:0]                  base_ext;
  logic [31:0]                  addr_ext;
  logic                         fin;

  // a start mark clears the request state before the byte is parsed
  assign phase_cur = s1_sor_r ? PH_HEADER : phase_r;
  assign scan_cur  = s1_sor_r ? hupw_pkg::SCAN_CLEAR : scan_r;

  hupw_hdr_scan u_hdr_scan (
    .byte_value (s1_byte_r),
    .scan_cur   (scan_cur),
    .scan_nxt   (scan_out),
    .hdr_end    (hdr_end)
  );

  assign base_ext  = 32'(base_r);
  assign addr_ext  = 32'(wr_addr_r);
  assign addr_full = wr_addr_r >> SB_LOG;
  assign sec_cur   = addr_full[SEC_W-1:0];
  assign rc_inc    = rc_r + 1'b1;
  assign fin       = ({1'b0, rc_inc} >= scan_r.len);

  // result fields
  logic                         res_valid;
  logic                         res_kind;
  logic [hupw_pkg::BYTE_W-1:0]  res_byte;
  logic [hupw_pkg::FLASH_W-1:0] res_addr;
  logic                         res_erase;
  logic                         res_page_end;
  logic                         res_last;
  logic [hupw_pkg::COUNT_W-1:0] res_count;

  always_comb begin
    phase_nxt     = phase_cur;
    scan_nxt      = scan_cur;
    rc_nxt        = rc_r;
    wr_addr_nxt   = wr_addr_r;
    sec_nxt       = sec_r;
    sec_valid_nxt = sec_valid_r;
    res_valid     = 1'b0;
    res_kind      = hupw_pkg::KIND_BODY;
    res_byte      = '0;
    res_addr      = '0;
    res_erase     = 1'b0;
    res_page_end  = 1'b0;
    res_last      = 1'b0;
    res_count     = '0;

    unique case (phase_cur)
      PH_HEADER: begin
        scan_nxt = scan_out;
        if (hdr_end) begin
          if (scan_out.len == '0 || scan_out.len > {1'b0, max_len_r}) begin
            // bad content length, one reject transfer
            phase_nxt = PH_DONE;
            res_valid = 1'b1;
            res_kind  = hupw_pkg::KIND_REJECT;
            res_last  = 1'b1;
          end else begin
            phase_nxt     = PH_BODY;
            wr_addr_nxt   = base_ext[ADDRESS_BITS-1:0];
            rc_nxt        = '0;
            sec_valid_nxt = 1'b0;
          end
        end
      end
      PH_BODY: begin
        res_valid     = 1'b1;
        res_byte      = s1_byte_r;
        res_addr      = addr_ext[hupw_pkg::FLASH_W-1:0];
        res_erase     = !sec_valid_r || (sec_cur != sec_r);
        res_page_end  = fin || (rc_inc[PG_LOG-1:0] == '0);
        res_last      = fin;
        res_count     = rc_inc;
        sec_nxt       = sec_cur;
        sec_valid_nxt = 1'b1;
        rc_nxt        = rc_inc;
        wr_addr_nxt   = wr_addr_r + 1'b1;
        if (fin) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        // finished or unused code, bytes are dropped until the next start
        phase_nxt = phase_cur;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // state and result register
  // --------------------------------------------------------------------------
  logic                         out_kind_r;
  logic [hupw_pkg::BYTE_W-1:0]  out_byte_r;
  logic [hupw_pkg::FLASH_W-1:0] out_addr_r;
  logic                         out_erase_r;
  logic                         out_page_end_r;
  logic                         out_last_r;
  logic [hupw_pkg::COUNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      scan_r      <= hupw_pkg::SCAN_CLEAR;
      rc_r        <= '0;
      wr_addr_r   <= '0;
      sec_r       <= '0;
      sec_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go) begin
        phase_r     <= phase_nxt;
        scan_r      <= scan_nxt;
        rc_r        <= rc_nxt;
        wr_addr_r   <= wr_addr_nxt;
        sec_r       <= sec_nxt;
        sec_valid_r <= sec_valid_nxt;
        out_valid_r <= res_valid;
        if (res_valid) begin
          out_kind_r     <= res_kind;
          out_byte_r     <= res_byte;
          out_addr_r     <= res_addr;
          out_erase_r    <= res_erase;
          out_page_end_r <= res_page_end;
          out_last_r     <= res_last;
          out_count_r    <= res_count;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_body_byte      = out_byte_r;
  assign out_flash_address  = out_addr_r;
  assign out_erase_sector   = out_erase_r;
  assign out_page_end       = out_page_end_r;
  assign out_last           = out_last_r;
  assign out_bytes_received = out_count_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // while in the body the count stays below the content length
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> ({1'b0, rc_r} < scan_r.len))
    else $error("body count reached content length without leaving body phase");

  // a last transfer closes the request
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && res_valid && res_last |=> phase_r == PH_DONE)
    else $error("phase not finished after last transfer");

  // reject transfers carry only the kind and last mark
  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == hupw_pkg::KIND_REJECT |->
      out_last_r && out_count_r == '0 && !out_erase_r && !out_page_end_r)
    else $error("malformed reject transfer");

  // the first body byte of a request always asks for an erase
  a_first_erase: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && phase_cur == PH_BODY && !sec_valid_r |-> res_erase)
    else $error("first body byte without sector erase");

endmodule

`default_nettype wire

>>> src/hupw_hdr_scan.sv
// ----------------------------------------------------------------------------
// hupw_hdr_scan
// one byte step of the header scanner: key match, length digits, end of header
// ----------------------------------------------------------------------------
`default_nettype none

module hupw_hdr_scan (
  input  wire logic [hupw_pkg::BYTE_W-1:0] byte_value,
  input  wire hupw_pkg::scan_state_t       scan_cur,
  output hupw_pkg::scan_state_t            scan_nxt,
  output logic                             hdr_end
);

  logic [hupw_pkg::BYTE_W-1:0] folded;
  logic                        is_blank;
  logic                        is_digit;
  logic [hupw_pkg::PIDX_W-1:0] pidx_step;
  logic [hupw_pkg::LEN_W+3:0]  acc;
  logic [hupw_pkg::LEN_W+3:0]  len_ext;

  assign folded   = (byte_value >= "a" && byte_value <= "z") ? byte_value - 8'd32 : byte_value;
  assign is_blank = (byte_value == " ") || (byte_value == 8'h09);
  assign is_digit = (byte_value >= "0") && (byte_value <= "9");
  assign len_ext  = (hupw_pkg::LEN_W + 4)'(scan_cur.len);
  // len * 10 + digit
  assign acc = (len_ext << 3) + (len_ext << 1) + (hupw_pkg::LEN_W + 4)'(byte_value - "0");

  always_comb begin
    scan_nxt  = scan_cur;
    pidx_step = '0;
    hdr_end   = 1'b0;

    unique case (scan_cur.np)
      hupw_pkg::NP_SEARCH: begin
        if (scan_cur.pidx < hupw_pkg::PIDX_W'(hupw_pkg::KEY_LEN) &&
            folded == hupw_pkg::key_char(scan_cur.pidx)) begin
          pidx_step = scan_cur.pidx + 1'b1;
        end else begin
          // restart, a mismatching byte that equals the first key letter begins a new try
          pidx_step = (folded == hupw_pkg::key_char('0)) ? hupw_pkg::PIDX_W'(1) : '0;
        end
        scan_nxt.pidx = pidx_step;
        if (pidx_step >= hupw_pkg::PIDX_W'(hupw_pkg::KEY_LEN)) begin
          scan_nxt.np = hupw_pkg::NP_SKIP;
        end
      end
      hupw_pkg::NP_SKIP, hupw_pkg::NP_DIGITS: begin
        if (scan_cur.np == hupw_pkg::NP_SKIP && is_blank) begin
          scan_nxt.np = scan_cur.np;
        end else if (is_digit) begin
          if (scan_cur.len > hupw_pkg::LEN_SAT ||
              acc > (hupw_pkg::LEN_W + 4)'(hupw_pkg::LEN_MAX)) begin
            scan_nxt.len = hupw_pkg::LEN_MAX;
          end else begin
            scan_nxt.len = acc[hupw_pkg::LEN_W-1:0];
          end
          scan_nxt.np = hupw_pkg::NP_DIGITS;
        end else begin
          scan_nxt.np = hupw_pkg::NP_OVER;
        end
      end
      hupw_pkg::NP_OVER: begin
        scan_nxt.np = scan_cur.np;
      end
    endcase

    // CR LF CR LF tracker
    if (byte_value == 8'h0D) begin
      scan_nxt.crlf = (scan_cur.crlf == 2'd2) ? 2'd3 : 2'd1;
    end else if (byte_value == 8'h0A) begin
      if (scan_cur.crlf == 2'd3) begin
        scan_nxt.crlf = 2'd0;
        hdr_end       = 1'b1;
      end else begin
        scan_nxt.crlf = (scan_cur.crlf == 2'd1) ? 2'd2 : 2'd0;
      end
    end else begin
      scan_nxt.crlf = 2'd0;
    end
  end

endmodule

`default_nettype wire
